@@ sv/bft_pkg.sv @@
package bft_pkg;

    localparam int CUR_W           = 13;
    localparam int CFG_W           = 13;
    localparam int DEF_GLYPH_ROWS  = 16;
    localparam int DEF_GLYPH_COUNT = 256;
    localparam int GLYPH_COLS      = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CUR_W-1:0] HOME_X      = 13'd10;
    localparam logic [CUR_W-1:0] HOME_Y      = 13'd10;
    localparam logic [CUR_W-1:0] WRAP_MARGIN = 13'd10;
    localparam logic [CUR_W-1:0] CURSOR_MAX  = 13'd8191;
    localparam logic [7:0]       CODE_NEWLINE = 8'd10;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd1024;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd768;
    localparam logic [CFG_W-1:0] RST_PITCH  = 13'd1024;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_PRINT = 2'd1;
    localparam logic [1:0] MODE_ERASE = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PITCH  = 2'd2;

    typedef struct packed {
        logic             is_load;
        logic [7:0]       code;
        logic [31:0]      colour;
        logic [3:0]       row;
        logic [7:0]       bits;
        logic [CUR_W-1:0] cx;
        logic [CUR_W-1:0] cy;
    } t_job;

endpackage

@@ sv/bft_front.sv @@
module bft_front
    import bft_pkg::*;
#(
    parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_full,
    input  logic [1:0]       i_mode,
    input  logic [7:0]       i_char_code,
    input  logic [31:0]      i_colour,
    input  logic [3:0]       i_glyph_row,
    input  logic [7:0]       i_glyph_bits,
    input  logic [CFG_W-1:0] i_screen_width,
    output logic             o_push,
    output t_job             o_job
);

    logic [CUR_W-1:0] r_x, r_y;
    logic [CUR_W-1:0] n_x, n_y;
    logic             accept;
    logic             code_ok;
    logic [CUR_W:0]   x_step;
    logic [CUR_W-1:0] x_sat;
    logic [CUR_W:0]   wrap_sum;
    logic [CUR_W:0]   y_step;
    logic [CUR_W-1:0] y_next_line;

    function automatic logic [CUR_W-1:0] sat_cur(input logic [CUR_W:0] v);
        return v[CUR_W] ? CURSOR_MAX : v[CUR_W-1:0];
    endfunction

    assign accept      = i_valid && !i_full;
    assign code_ok     = 32'(i_char_code) < GLYPH_COUNT;
    assign x_step      = {1'b0, r_x} + (CUR_W+1)'(GLYPH_COLS);
    assign x_sat       = sat_cur(x_step);
    assign wrap_sum    = {1'b0, x_sat} + {1'b0, WRAP_MARGIN};
    assign y_step      = {1'b0, r_y} + (CUR_W+1)'(GLYPH_ROWS);
    assign y_next_line = sat_cur(y_step);

    always_comb begin
        n_x          = r_x;
        n_y          = r_y;
        o_push       = 1'b0;
        o_job.is_load = 1'b0;
        o_job.code   = i_char_code;
        o_job.colour = i_colour;
        o_job.row    = i_glyph_row;
        o_job.bits   = i_glyph_bits;
        o_job.cx     = r_x;
        o_job.cy     = r_y;
        case (i_mode)
            MODE_LOAD: begin
                o_job.is_load = 1'b1;
                o_push = accept && code_ok && (32'(i_glyph_row) < GLYPH_ROWS);
            end
            MODE_PRINT: begin
                if (i_char_code == CODE_NEWLINE) begin
                    n_x = HOME_X;
                    n_y = y_next_line;
                end else begin
                    o_push = accept && code_ok;
                    if (wrap_sum > {1'b0, i_screen_width}) begin
                        n_x = HOME_X;
                        n_y = y_next_line;
                    end else begin
                        n_x = x_sat;
                    end
                end
            end
            MODE_ERASE: begin
                n_x = (r_x >= CUR_W'(GLYPH_COLS)) ? r_x - CUR_W'(GLYPH_COLS) : '0;
                o_job.cx     = n_x;
                o_job.colour = '0;
                o_push       = accept && code_ok;
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= HOME_X;
            r_y <= HOME_Y;
        end else if (accept) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

endmodule

@@ sv/bft_queue.sv @@
module bft_queue
    import bft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job                r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wr, r_rd;
    logic [PTR_W:0]      r_count;

    assign o_full     = r_count == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_job      = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/bft_back.sv @@
module bft_back
    import bft_pkg::*;
#(
    parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_pop,
    input  logic [CFG_W-1:0] i_screen_width,
    input  logic [CFG_W-1:0] i_screen_height,
    input  logic [CFG_W-1:0] i_line_pitch,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [23:0]      o_pixel_index,
    output logic [7:0]       o_pixel_mask,
    output logic [31:0]      o_pixel_colour,
    output logic             o_last_row
);

    localparam int ROW_W  = $clog2(GLYPH_ROWS);
    localparam int ADDR_W = $clog2(GLYPH_COUNT * GLYPH_ROWS);
    localparam int LIM_W  = 2 * CFG_W;
    localparam int PROD_W = CUR_W + 1 + CFG_W;
    localparam int BASE_W = PROD_W + 1;
    localparam int DIFF_W = PROD_W + 2;

    logic [7:0]           r_glyph [GLYPH_COUNT * GLYPH_ROWS];
    logic [LIM_W-1:0]     r_limit;

    logic                 r_job_v;
    logic [ROW_W-1:0]     r_row;
    logic [7:0]           r_code;
    logic [31:0]          r_colour;
    logic [CUR_W-1:0]     r_cx, r_cy;

    logic                 r_s1_v;
    logic [PROD_W-1:0]    r_s1_prod;
    logic [CUR_W-1:0]     r_s1_cx;
    logic [DIFF_W-1:0]    r_s1_lmx;
    logic [31:0]          r_s1_colour;
    logic                 r_s1_last;
    logic [7:0]           r_rdata;

    logic                 en;
    logic                 last_issue;
    logic                 we;
    logic [ADDR_W-1:0]    waddr, raddr;
    logic [CUR_W:0]       row_y;
    logic [BASE_W-1:0]    base;
    logic [DIFF_W-1:0]    diff;
    logic [7:0]           n_mask;

    assign en         = !o_valid || !i_stall;
    assign last_issue = r_job_v && (r_row == ROW_W'(GLYPH_ROWS-1));
    assign o_pop      = en && i_job_valid && (!r_job_v || last_issue);
    assign we         = o_pop && i_job.is_load;
    assign waddr      = ADDR_W'(32'(i_job.code) * GLYPH_ROWS + 32'(i_job.row));
    assign raddr      = ADDR_W'(32'(r_code) * GLYPH_ROWS + 32'(r_row));
    assign row_y      = {1'b0, r_cy} + (CUR_W+1)'(r_row);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_glyph[waddr] <= i_job.bits;
        end
        if (en) begin
            r_rdata <= r_glyph[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= LIM_W'(i_screen_width) * LIM_W'(i_screen_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_row   <= '0;
        end else begin
            if (o_pop && !i_job.is_load) begin
                r_job_v <= 1'b1;
                r_row   <= '0;
            end else if (en && r_job_v) begin
                if (last_issue) begin
                    r_job_v <= 1'b0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_job.is_load) begin
            r_code   <= i_job.code;
            r_colour <= i_job.colour;
            r_cx     <= i_job.cx;
            r_cy     <= i_job.cy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_job_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_prod   <= PROD_W'(row_y) * PROD_W'(i_line_pitch);
            r_s1_cx     <= r_cx;
            r_s1_lmx    <= DIFF_W'(r_limit) - DIFF_W'(r_cx);
            r_s1_colour <= r_colour;
            r_s1_last   <= last_issue;
        end
    end

    assign base = BASE_W'(r_s1_cx) + BASE_W'(r_s1_prod);
    assign diff = r_s1_lmx - DIFF_W'(r_s1_prod);

    always_comb begin
        for (int c = 0; c < GLYPH_COLS; c++) begin
            n_mask[7-c] = r_rdata[7-c] && !diff[DIFF_W-1]
                          && (diff[DIFF_W-2:0] > (DIFF_W-1)'(c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pixel_index  <= base[23:0];
            o_pixel_mask   <= n_mask;
            o_pixel_colour <= r_s1_colour;
            o_last_row     <= r_s1_last;
        end
    end

endmodule

@@ sv/bitmap_font_text_renderer.sv @@
// Text console renderer with a loadable 8-pixel-wide bitmap font.
// Input channel (i_valid / o_stall): one word per item. Mode 0 writes one glyph
// row into the glyph store, mode 1 prints a character (code 10 is a newline),
// mode 2 steps the cursor back and redraws the glyph there in colour 0.
// Output channel (o_valid / i_stall): one word per glyph row, top row first,
// o_last_row set on the final row of a glyph.
// Row path: job queue, row counter, glyph store read with stage-1 registers,
// then the output registers.
// Throughput: one row word per cycle while i_stall is low, set by the single
// glyph store read port; the next job leaves the queue with the last row of a
// glyph. Newlines and cursor-only items never enter the queue. A two-entry
// job queue sits between the cursor logic and the row generator.
// Configuration: APB, width at 0x0, height at 0x4, line pitch at 0x8; write
// only while the block is idle.
// Reset: cursor goes to (10, 10), registers to 1024 x 768, pitch 1024; the glyph
// store is not cleared and must be loaded before use.
// Stall: when i_stall holds a word, the whole row pipeline freezes and the
// queue fills; o_stall rises once the queue is full.
module bitmap_font_text_renderer
    import bft_pkg::*;
#(
    parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
    parameter int GLYPH_COUNT = DEF_GLYPH_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_colour,
    input  logic [3:0]  i_glyph_row,
    input  logic [7:0]  i_glyph_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_pixel_index,
    output logic [7:0]  o_pixel_mask,
    output logic [31:0] o_pixel_colour,
    output logic        o_last_row,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_W-1:0] r_width, r_height, r_pitch;
    logic             cfg_we;
    logic [1:0]       cfg_idx;
    logic             push, pop, full, nonempty;
    t_job             front_job, head_job;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];
    assign o_stall = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_pitch  <= RST_PITCH;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                REG_PITCH:  r_pitch  <= pwdata[CFG_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_PITCH:  prdata = 32'(r_pitch);
            default:    prdata = '0;
        endcase
    end

    bft_front #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_full         (full),
        .i_mode         (i_mode),
        .i_char_code    (i_char_code),
        .i_colour       (i_colour),
        .i_glyph_row    (i_glyph_row),
        .i_glyph_bits   (i_glyph_bits),
        .i_screen_width (r_width),
        .o_push         (push),
        .o_job          (front_job)
    );

    bft_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (front_job),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_job      (head_job)
    );

    bft_back #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (nonempty),
        .i_job           (head_job),
        .o_pop           (pop),
        .i_screen_width  (r_width),
        .i_screen_height (r_height),
        .i_line_pitch    (r_pitch),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pixel_index   (o_pixel_index),
        .o_pixel_mask    (o_pixel_mask),
        .o_pixel_colour  (o_pixel_colour),
        .o_last_row      (o_last_row)
    );

endmodule
